// ===== rtl/pip4_pkg.sv =====
// Shared types and constants for the 4bpp palette index packer.
`default_nettype none

package pip4_pkg;

  // Fixed field widths
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_LOAD_FULL = 2'd3;

  // Input word
  typedef struct packed {
    logic               func;
    logic [COLOR_W-1:0] first_color;
    logic [COLOR_W-1:0] second_color;
    logic               second_valid;
  } pip4_in_t;

  // Result word
  typedef struct packed {
    logic [COLOR_W-1:0] packed_byte;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] palette_count;
  } pip4_out_t;

  // Per-lane compare result
  typedef struct packed {
    logic first_hit;
    logic second_hit;
  } pip4_hit_t;

  // Merged lookup result
  typedef struct packed {
    logic             found;
    logic [NIB_W-1:0] idx;
  } pip4_match_t;

endpackage

`default_nettype wire

// ===== rtl/palette_index_packer_4bpp_unit.sv =====
// Top level of the 4bpp palette index packer.
`default_nettype none

// Each input word carries a pair of 8-bit colors (or one palette entry to
// load) and yields one registered result word: two 4-bit palette indices
// packed first-in-high-nibble, a status code and the palette fill count
// after the word. One word is taken per clock unless stalled; the palette
// sits in PALETTE_DEPTH registers compared in parallel lanes, so a whole
// pair, including appending up to two new colors, resolves at once.
// The output register lets a new word enter in the same cycle the held
// result is taken. Write cfg_wdata = 1 (via cfg_we) only while idle to fix
// the palette; load words append entries regardless of that bit.
module palette_index_packer_4bpp_unit #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pip4_pkg::pip4_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pip4_pkg::pip4_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  localparam logic [pip4_pkg::COUNT_W-1:0] DEPTH_CNT = pip4_pkg::COUNT_W'(PALETTE_DEPTH);

  logic [pip4_pkg::COLOR_W-1:0] pal_r   [PALETTE_DEPTH];
  logic [pip4_pkg::COLOR_W-1:0] pal_nxt [PALETTE_DEPTH];
  logic [pip4_pkg::COUNT_W-1:0] used_r, used_nxt, used_mid;
  logic                         fixed_r;
  logic                         out_valid_r, out_valid_nxt;
  pip4_pkg::pip4_out_t          out_data_r, out_data_nxt;

  logic                         in_acc;
  logic [PALETTE_DEPTH-1:0]     hits1, hits2;
  pip4_pkg::pip4_hit_t          lane_hit [PALETTE_DEPTH];
  pip4_pkg::pip4_match_t        m1, m2;

  logic                         ins1, ins2, found2, ok1, ok2, same_c;
  logic [pip4_pkg::NIB_W-1:0]   idx1, idx2;
  logic                         wr1, wr2;
  logic [pip4_pkg::COUNT_W-1:0] waddr1, waddr2;
  logic [pip4_pkg::COLOR_W-1:0] wdata1;

  // Stall input only while a held result is blocked
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Compare lanes, one per palette entry
  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_lane
    pip4_lane u_lane (
      .entry_color  (pal_r[g]),
      .entry_used   (used_r > pip4_pkg::COUNT_W'(g)),
      .first_color  (in_data.first_color),
      .second_color (in_data.second_color),
      .hit          (lane_hit[g])
    );
    assign hits1[g] = lane_hit[g].first_hit;
    assign hits2[g] = lane_hit[g].second_hit;
  end

  // Merge lane hits for each color
  pip4_merge #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_merge1 (.hits(hits1), .match(m1));
  pip4_merge #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_merge2 (.hits(hits2), .match(m2));

  // Resolve indices, insertions and the result word
  always_comb begin
    same_c   = in_data.second_color == in_data.first_color;
    ins1     = !m1.found && !fixed_r && (used_r < DEPTH_CNT);
    ok1      = m1.found || ins1;
    idx1     = m1.found ? m1.idx : used_r[pip4_pkg::NIB_W-1:0];
    used_mid = used_r + pip4_pkg::COUNT_W'(ins1);

    // Second color sees the first color's insertion
    found2 = m2.found || (ins1 && same_c);
    ins2   = in_data.second_valid && !found2 && !fixed_r && (used_mid < DEPTH_CNT);
    if (!in_data.second_valid) begin
      idx2 = '0;
      ok2  = 1'b1;
    end else if (m2.found) begin
      idx2 = m2.idx;
      ok2  = 1'b1;
    end else if (found2) begin
      idx2 = used_r[pip4_pkg::NIB_W-1:0];
      ok2  = 1'b1;
    end else begin
      idx2 = used_mid[pip4_pkg::NIB_W-1:0];
      ok2  = ins2;
    end

    wr1    = 1'b0;
    wr2    = 1'b0;
    waddr1 = used_r;
    waddr2 = used_mid;
    wdata1 = in_data.first_color;
    out_data_nxt.packed_byte = '0;
    out_data_nxt.status      = pip4_pkg::ST_OK;
    used_nxt                 = used_r;

    case (in_data.func)
      pip4_pkg::FUNC_LOAD: begin
        if (used_r < DEPTH_CNT) begin
          wr1      = in_acc;
          used_nxt = used_r + pip4_pkg::COUNT_W'(1);
        end else begin
          out_data_nxt.status = pip4_pkg::ST_LOAD_FULL;
        end
      end
      pip4_pkg::FUNC_CONVERT: begin
        wr1      = in_acc && ins1;
        wr2      = in_acc && ins2;
        used_nxt = used_mid + pip4_pkg::COUNT_W'(ins2);
        if (ok1 && ok2) begin
          out_data_nxt.packed_byte = {idx1, idx2};
        end else begin
          out_data_nxt.status = fixed_r ? pip4_pkg::ST_NOT_FOUND : pip4_pkg::ST_FULL;
        end
      end
      default: begin
        out_data_nxt.status = pip4_pkg::ST_OK;
      end
    endcase
    out_data_nxt.palette_count = used_nxt;
  end

  // Palette entry write-back
  always_comb begin
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      pal_nxt[i] = pal_r[i];
      if (wr1 && (waddr1 == pip4_pkg::COUNT_W'(i))) begin
        pal_nxt[i] = wdata1;
      end
      if (wr2 && (waddr2 == pip4_pkg::COUNT_W'(i))) begin
        pal_nxt[i] = in_data.second_color;
      end
    end
  end

  // Output valid: load on accept, drop when taken
  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      fixed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        used_r <= used_nxt;
      end
      if (cfg_we) begin
        fixed_r <= cfg_wdata;
      end
    end
  end

  // Payload: palette entries and result word
  always_ff @(posedge clk) begin
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      pal_r[i] <= pal_nxt[i];
    end
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pip4_lane.sv =====
// One compare lane: matches both colors of a word against one palette entry.
`default_nettype none

module pip4_lane (
  input  wire logic [pip4_pkg::COLOR_W-1:0] entry_color,
  input  wire logic                         entry_used,
  input  wire logic [pip4_pkg::COLOR_W-1:0] first_color,
  input  wire logic [pip4_pkg::COLOR_W-1:0] second_color,
  output pip4_pkg::pip4_hit_t               hit
);

  // Match only entries already in use
  always_comb begin
    hit.first_hit  = entry_used && (entry_color == first_color);
    hit.second_hit = entry_used && (entry_color == second_color);
  end

endmodule

`default_nettype wire

// ===== rtl/pip4_merge.sv =====
// Merge stage: picks the lowest matching lane out of the hit vector.
`default_nettype none

module pip4_merge #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  wire logic [PALETTE_DEPTH-1:0] hits,
  output pip4_pkg::pip4_match_t         match
);

  // Priority encode, lowest index wins
  always_comb begin
    match.found = |hits;
    match.idx   = '0;
    for (int i = PALETTE_DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match.idx = pip4_pkg::NIB_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pip4_checker.sv =====
// Port-level checker for the 4bpp palette index packer, bound to the top level.
`default_nettype none

module pip4_checker #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pip4_pkg::pip4_out_t out_data
);

  localparam logic [pip4_pkg::COUNT_W-1:0] DEPTH_CNT = pip4_pkg::COUNT_W'(PALETTE_DEPTH);

  // A blocked result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Every accepted word yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  // Fill count never passes the palette depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.palette_count <= DEPTH_CNT)
    else $error("palette count beyond depth");

  // Full statuses only with a full palette and a zero packed byte
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pip4_pkg::ST_FULL ||
                  out_data.status == pip4_pkg::ST_LOAD_FULL)
      |-> out_data.palette_count == DEPTH_CNT && out_data.packed_byte == '0)
    else $error("full status with room left or nonzero byte");

endmodule

bind palette_index_packer_4bpp_unit pip4_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_pip4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
